[design/fql_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fql_pkg
// Shared widths, defaults and codes for the FIFO queued lock.
// ----------------------------------------------------------------------------
package fql_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_WIDTH_DEF    = 8;

    localparam int THREAD_ID_W = 8;
    localparam int STATUS_W    = 3;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_GRANTED    = 3'd0;
    localparam status_t ST_WAITING    = 3'd1;
    localparam status_t ST_RECURSIVE  = 3'd2;
    localparam status_t ST_UNLOCK_ERR = 3'd3;
    localparam status_t ST_FULL       = 3'd4;

    localparam logic MODE_LOCK   = 1'b0;
    localparam logic MODE_UNLOCK = 1'b1;

endpackage

[design/fifo_queued_lock.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queued_lock
// Mutex whose holder and waiters sit in a circular queue of thread ids.
// ----------------------------------------------------------------------------
// Each lock or unlock request returns one response: status, the holder after
// the request, and a handover flag. The queue lives in a simple dual-port
// memory with a registered read. A request steps through fetching the front
// entry, the update and publishing, plus a second fetch of the new front
// entry when an unlock hands the lock to a waiter. A finished response waits
// in the output register while the next request is taken. The queue memory
// is not cleared at reset; only written entries are ever used.
module fifo_queued_lock #(
    parameter int QUEUE_DEPTH = fql_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_WIDTH    = fql_pkg::ID_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_mode,
    input  logic [fql_pkg::THREAD_ID_W-1:0]  s_thread_id,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [fql_pkg::STATUS_W-1:0]     m_status,
    output logic                             m_holder_valid,
    output logic [fql_pkg::THREAD_ID_W-1:0]  m_holder_id,
    output logic                             m_handover
);
    import fql_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int EXT_W = 16;

    localparam logic [CNT_W-1:0] DEPTH_C    = CNT_W'(QUEUE_DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_S    = SUM_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR_C = PTR_W'(QUEUE_DEPTH - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_FETCH = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [ID_WIDTH-1:0] queue_mem [QUEUE_DEPTH];
    logic [ID_WIDTH-1:0] rd_data_reg;
    logic [PTR_W-1:0]    rd_addr;
    logic                wr_en;

    logic [1:0]          state_reg, state_next;
    logic [PTR_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                mode_reg;
    logic [ID_WIDTH-1:0] id_reg;

    status_t             res_status_reg, res_status_next;
    logic                res_hvalid_reg, res_hvalid_next;
    logic [ID_WIDTH-1:0] res_hid_reg, res_hid_next;
    logic                res_hand_reg, res_hand_next;

    logic                m_valid_reg;
    status_t             m_status_reg;
    logic                m_hvalid_reg;
    logic [THREAD_ID_W-1:0] m_hid_reg;
    logic                m_hand_reg;

    logic [EXT_W-1:0]    in_id_ext;
    logic [EXT_W-1:0]    hid_ext;
    logic [SUM_W-1:0]    tail_sum;
    logic [PTR_W-1:0]    tail_ptr;
    logic [PTR_W-1:0]    head_inc;
    logic                pub;

    assign in_id_ext = EXT_W'(s_thread_id);
    assign hid_ext   = EXT_W'(res_hid_reg);

    assign tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    always_comb begin
        if (tail_sum >= DEPTH_S) begin
            tail_ptr = PTR_W'(tail_sum - DEPTH_S);
        end else begin
            tail_ptr = PTR_W'(tail_sum);
        end
    end

    assign head_inc = (head_reg == LAST_PTR_C) ? '0 : head_reg + 1'b1;

    assign s_ready = (state_reg == S_IDLE);
    assign pub     = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            queue_mem[tail_ptr] <= id_reg;
        end
        rd_data_reg <= queue_mem[rd_addr];
    end

    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_hvalid_next = res_hvalid_reg;
        res_hid_next    = res_hid_reg;
        res_hand_next   = res_hand_reg;
        wr_en           = 1'b0;
        rd_addr         = head_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next    = S_DONE;
                res_hand_next = 1'b0;
                res_hid_next  = rd_data_reg;
                if (mode_reg == MODE_LOCK) begin
                    priority if (count_reg == '0) begin
                        wr_en           = 1'b1;
                        count_next      = count_reg + 1'b1;
                        res_status_next = ST_GRANTED;
                        res_hid_next    = id_reg;
                    end else if (rd_data_reg == id_reg) begin
                        res_status_next = ST_RECURSIVE;
                    end else if (count_reg >= DEPTH_C) begin
                        res_status_next = ST_FULL;
                    end else begin
                        wr_en           = 1'b1;
                        count_next      = count_reg + 1'b1;
                        res_status_next = ST_WAITING;
                    end
                    res_hvalid_next = 1'b1;
                end else begin
                    if (count_reg == '0 || rd_data_reg != id_reg) begin
                        res_status_next = ST_UNLOCK_ERR;
                        res_hvalid_next = (count_reg != '0);
                    end else begin
                        head_next       = head_inc;
                        count_next      = count_reg - 1'b1;
                        res_status_next = ST_GRANTED;
                        res_hvalid_next = (count_next != '0);
                        res_hand_next   = (count_next != '0);
                        rd_addr         = head_inc;
                        if (count_next != '0) begin
                            state_next = S_FETCH;
                        end
                    end
                end
            end
            S_FETCH: begin
                res_hid_next = rd_data_reg;
                state_next   = S_DONE;
            end
            S_DONE: begin
                if (pub) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            if (pub) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            mode_reg <= s_mode;
            id_reg   <= in_id_ext[ID_WIDTH-1:0];
        end
        res_status_reg <= res_status_next;
        res_hvalid_reg <= res_hvalid_next;
        res_hid_reg    <= res_hid_next;
        res_hand_reg   <= res_hand_next;
        if (pub) begin
            m_status_reg <= res_status_reg;
            m_hvalid_reg <= res_hvalid_reg;
            m_hid_reg    <= res_hvalid_reg ? hid_ext[THREAD_ID_W-1:0] : '0;
            m_hand_reg   <= res_hand_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_holder_valid = m_hvalid_reg;
    assign m_holder_id    = m_hid_reg;
    assign m_handover     = m_hand_reg;

endmodule

[tb/fifo_queued_lock_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queued_lock_chk
// Watches both channels of the queued lock, predicts every response from the
// accepted requests, and compares the responses field by field, in order.
// ----------------------------------------------------------------------------
module fifo_queued_lock_chk #(
    parameter int QUEUE_DEPTH = fql_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_WIDTH    = fql_pkg::ID_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic                            s_mode,
    input  logic [fql_pkg::THREAD_ID_W-1:0] s_thread_id,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [fql_pkg::STATUS_W-1:0]    m_status,
    input  logic                            m_holder_valid,
    input  logic [fql_pkg::THREAD_ID_W-1:0] m_holder_id,
    input  logic                            m_handover,
    output int                              mismatches,
    output int                              awaiting
);
    import fql_pkg::*;

    typedef struct packed {
        status_t                status;
        logic                   holder_valid;
        logic [THREAD_ID_W-1:0] holder_id;
        logic                   handover;
    } lock_resp_t;

    logic [THREAD_ID_W-1:0] slot_ids [QUEUE_DEPTH];
    int                     head_idx  = 0;
    int                     entry_cnt = 0;
    lock_resp_t             resp_q[$];
    int                     fail_cnt  = 0;

    function automatic void enqueue_id(input logic [THREAD_ID_W-1:0] tid);
        slot_ids[(head_idx + entry_cnt) % QUEUE_DEPTH] = tid;
        entry_cnt++;
    endfunction

    function automatic lock_resp_t apply_request(input logic mode,
                                                 input logic [THREAD_ID_W-1:0] tid);
        lock_resp_t             r;
        logic [THREAD_ID_W-1:0] id_m;
        id_m = tid & THREAD_ID_W'((1 << ID_WIDTH) - 1);
        r = '0;
        if (mode == MODE_LOCK) begin
            if (entry_cnt == 0) begin
                enqueue_id(id_m);
                r.status = ST_GRANTED;
            end else if (slot_ids[head_idx] == id_m) begin
                r.status = ST_RECURSIVE;
            end else if (entry_cnt >= QUEUE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                enqueue_id(id_m);
                r.status = ST_WAITING;
            end
        end else begin
            if (entry_cnt == 0 || slot_ids[head_idx] != id_m) begin
                r.status = ST_UNLOCK_ERR;
            end else begin
                head_idx = (head_idx + 1) % QUEUE_DEPTH;
                entry_cnt--;
                r.status   = ST_GRANTED;
                r.handover = (entry_cnt > 0);
            end
        end
        r.holder_valid = (entry_cnt > 0);
        r.holder_id    = (entry_cnt > 0) ? slot_ids[head_idx] : '0;
        return r;
    endfunction

    always @(posedge aclk) begin
        lock_resp_t want;
        if (!aresetn) begin
            head_idx  = 0;
            entry_cnt = 0;
            resp_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                resp_q.push_back(apply_request(s_mode, s_thread_id));
            end
            if (m_valid && m_ready) begin
                if (resp_q.size() == 0) begin
                    $error("response with no request pending: status %0d holder %0d/%0d",
                           m_status, m_holder_valid, m_holder_id);
                    fail_cnt++;
                end else begin
                    want = resp_q.pop_front();
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_status);
                        fail_cnt++;
                    end
                    if (m_holder_valid !== want.holder_valid) begin
                        $error("holder_valid: expected %0d, got %0d",
                               want.holder_valid, m_holder_valid);
                        fail_cnt++;
                    end
                    if (m_holder_id !== want.holder_id) begin
                        $error("holder_id: expected 0x%02h, got 0x%02h",
                               want.holder_id, m_holder_id);
                        fail_cnt++;
                    end
                    if (m_handover !== want.handover) begin
                        $error("handover: expected %0d, got %0d", want.handover, m_handover);
                        fail_cnt++;
                    end
                end
            end
        end
        mismatches <= fail_cnt;
        awaiting   <= resp_q.size();
    end

endmodule

[tb/fifo_queued_lock_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queued_lock_tb
// Drives lock and unlock requests into the queued lock: a directed opening
// through every status, then random request bursts over a few thread ids
// under sender and receiver idling, a long receiver stall and full drains.
// ----------------------------------------------------------------------------
module fifo_queued_lock_tb;
    import fql_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 375;
    localparam int SETTLE_CYCLES = 20;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_mode;
    logic [THREAD_ID_W-1:0] s_thread_id;
    logic                   m_valid;
    logic                   m_ready;
    logic [STATUS_W-1:0]    m_status;
    logic                   m_holder_valid;
    logic [THREAD_ID_W-1:0] m_holder_id;
    logic                   m_handover;

    int                     mismatches;
    int                     awaiting;
    int                     cycle_count = 0;
    int                     tx_idle_pct = 0;
    int                     rx_idle_pct = 0;
    logic                   hold_toggle = 1'b0;
    logic                   hold_seen   = 1'b0;
    int                     hold_left   = 0;
    logic [THREAD_ID_W-1:0] lock_line[$];
    logic [THREAD_ID_W-1:0] id_pool[4];

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    fifo_queued_lock dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_thread_id    (s_thread_id),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_holder_valid (m_holder_valid),
        .m_holder_id    (m_holder_id),
        .m_handover     (m_handover)
    );

    fifo_queued_lock_chk chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_thread_id    (s_thread_id),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_holder_valid (m_holder_valid),
        .m_holder_id    (m_holder_id),
        .m_handover     (m_handover),
        .mismatches     (mismatches),
        .awaiting       (awaiting)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("fifo_queued_lock_tb: done, errors");
            $finish;
        end
    end

    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_toggle != hold_seen) begin
                hold_seen = hold_toggle;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_request(input logic mode, input logic [THREAD_ID_W-1:0] tid);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_mode      <= mode;
        s_thread_id <= tid;
        do @(posedge aclk); while (!s_ready);
        // track the likely front so that most unlocks come from the holder
        if (mode == MODE_LOCK) begin
            if (lock_line.size() == 0 ||
                (lock_line[0] != tid && lock_line.size() < QUEUE_DEPTH_DEF)) begin
                lock_line.push_back(tid);
            end
        end else if (lock_line.size() > 0 && lock_line[0] == tid) begin
            void'(lock_line.pop_front());
        end
    endtask

    task automatic drain_responses();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (awaiting != 0) @(posedge aclk);
    endtask

    task automatic run_random(input int count);
        int                     lock_pct;
        logic                   mode;
        logic [THREAD_ID_W-1:0] tid;
        lock_pct = 50;
        for (int n = 0; n < count; n++) begin
            if (n % 24 == 0) begin
                foreach (id_pool[k]) id_pool[k] = THREAD_ID_W'($urandom_range(0, 255));
                lock_pct = $urandom_range(0, 1) ? 75 : 40;
            end
            if ($urandom_range(0, 99) < lock_pct) begin
                mode = MODE_LOCK;
                tid  = ($urandom_range(0, 9) == 0) ? THREAD_ID_W'($urandom_range(0, 255))
                                                   : id_pool[$urandom_range(0, 3)];
            end else begin
                mode = MODE_UNLOCK;
                if (lock_line.size() > 0 && $urandom_range(0, 99) < 80) begin
                    tid = lock_line[0];
                end else begin
                    tid = ($urandom_range(0, 3) == 0) ? THREAD_ID_W'($urandom_range(0, 255))
                                                      : id_pool[$urandom_range(0, 3)];
                end
            end
            send_request(mode, tid);
        end
    endtask

    initial begin
        s_valid     <= 1'b0;
        s_mode      <= MODE_LOCK;
        s_thread_id <= '0;
        aresetn     <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_request(MODE_UNLOCK, 8'h00);
        send_request(MODE_LOCK,   8'h00);
        send_request(MODE_LOCK,   8'h00);
        send_request(MODE_UNLOCK, 8'hFF);
        send_request(MODE_LOCK,   8'hFF);
        send_request(MODE_LOCK,   8'hFF);
        send_request(MODE_UNLOCK, 8'h00);
        send_request(MODE_UNLOCK, 8'hFF);
        for (int k = 0; k < QUEUE_DEPTH_DEF - 1; k++) begin
            send_request(MODE_LOCK, THREAD_ID_W'(1 + k * 17));
        end
        send_request(MODE_LOCK, 8'h5A);
        send_request(MODE_LOCK, 8'hFF);
        drain_responses();

        tx_idle_pct = 25;
        rx_idle_pct = 87;
        run_random(PHASE_ITEMS);
        drain_responses();

        tx_idle_pct = 87;
        rx_idle_pct = 25;
        run_random(PHASE_ITEMS);
        drain_responses();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(PHASE_ITEMS / 2);
        hold_toggle <= ~hold_toggle;
        run_random(PHASE_ITEMS - PHASE_ITEMS / 2);
        drain_responses();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && awaiting == 0) begin
            $display("fifo_queued_lock_tb: done, clean");
        end else begin
            $display("fifo_queued_lock_tb: done, errors");
        end
        $finish;
    end

endmodule

[sim.f]
design/fql_pkg.sv
design/fifo_queued_lock.sv
tb/fifo_queued_lock_chk.sv
tb/fifo_queued_lock_tb.sv
